FILE: rtl/core/aes128_block_encrypt_macros.svh
// assertion macros for the aes128 block
`ifndef AES128_BLOCK_ENCRYPT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_MACROS_SVH

// a property that must hold at every edge out of reset
`define AES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

FILE: rtl/core/aes_pkg.sv
`default_nettype none
package aes_pkg;

  localparam int Stages = 11;
  localparam logic [3:0] MaxRounds = 4'd10;

  typedef enum logic [1:0] {
    REG_ROUNDS = 2'd0,
    REG_KEY_HI = 2'd1,
    REG_KEY_LO = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
  } in_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_t;

  // per-stage control traveling with the data
  typedef struct packed {
    logic       vld;
    logic [3:0] rounds;
  } ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] step);
    logic [7:0] r;
    case (step)
      4'd0: r = 8'h01; 4'd1: r = 8'h02; 4'd2: r = 8'h04; 4'd3: r = 8'h08;
      4'd4: r = 8'h10; 4'd5: r = 8'h20; 4'd6: r = 8'h40; 4'd7: r = 8'h80;
      4'd8: r = 8'h1b; default: r = 8'h36;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the block sits at bits [127-8i -: 8]
  function automatic logic [7:0] byte_at(input logic [127:0] v, input int i);
    return v[127-8*i -: 8];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/aes_round.sv
`default_nettype none
// one pipeline stage: key step plus one cipher round, enabled by round count
module aes_round (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [3:0]      step,
  input  wire aes_pkg::ctl_t   ctl_in,
  input  wire logic [127:0]    st_in,
  input  wire logic [127:0]    key_in,
  output aes_pkg::ctl_t        ctl_out,
  output logic [127:0]         st_out,
  output logic [127:0]         key_out
);
  logic [127:0] key_nxt, st_nxt, sub, mix;
  logic [7:0]   t [4];
  logic [7:0]   a0, a1, a2, a3;
  logic         active, last;
  aes_pkg::ctl_t ctl_r;
  logic [127:0] st_r, key_r;

  assign active = ctl_in.rounds > step;
  assign last   = ctl_in.rounds == step + 4'd1;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      t[r] = aes_pkg::sbox(aes_pkg::byte_at(key_in, ((r + 1) % 4) * 4 + 3));
    end
    t[0] = t[0] ^ aes_pkg::rcon(step);
    key_nxt = key_in;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        key_nxt[127-8*(r*4+c) -: 8] = aes_pkg::byte_at(key_in, r*4+c) ^ t[r];
        t[r] = key_nxt[127-8*(r*4+c) -: 8];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        sub[127-8*(r*4+c) -: 8] = aes_pkg::sbox(aes_pkg::byte_at(st_in, r*4 + ((c + r) % 4)));
      end
    end
    mix = sub;
    for (int c = 0; c < 4; c++) begin
      a0 = aes_pkg::byte_at(sub, c);
      a1 = aes_pkg::byte_at(sub, c + 4);
      a2 = aes_pkg::byte_at(sub, c + 8);
      a3 = aes_pkg::byte_at(sub, c + 12);
      mix[127-8*c -: 8]      = aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
      mix[127-8*(c+4) -: 8]  = a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3;
      mix[127-8*(c+8) -: 8]  = a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3;
      mix[127-8*(c+12) -: 8] = aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3);
    end
    // rounds past the count just carry the state through
    st_nxt = active ? ((last ? sub : mix) ^ key_nxt) : st_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
    st_r  <= st_nxt;
    key_r <= key_nxt;
  end

  assign ctl_out = ctl_r;
  assign st_out  = st_r;
  assign key_out = key_r;
endmodule
`default_nettype wire

FILE: rtl/core/aes128_block_encrypt.sv
`default_nettype none
// aes-128 block encryption, fully pipelined.
// request channel: drive in_payload and pulse start while busy is low; busy
// is always low, so a new block can enter every clock.
// result channel: out_strobe is high for one cycle with out_payload; the
// receiver cannot stall and must take it then.
// pipeline: one input stage for the key xor, then ten round stages, each one
// sbox/mixcolumns round and one key expansion step; the strobe is the valid
// bit of the last round stage. throughput: one block per cycle.
// rounds beyond the configured count pass the state through unchanged, so
// latency does not depend on the count; counts above ten act as ten.
// the round count and key are sampled when a request enters.
// config: apb, 64-bit data, reg 0 round_count at 0x00, key_high at 0x08,
// key_low at 0x10. write only while no block is in flight.
// reset clears the pipeline valid bits and sets round_count to 10, key to 0.
module aes128_block_encrypt (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire aes_pkg::in_t  in_payload,
  output logic               out_strobe,
  output aes_pkg::out_t      out_payload,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [4:0]    cfg_paddr,
  input  wire logic [63:0]   cfg_pwdata,
  output logic [63:0]        cfg_prdata,
  output logic               cfg_pready
);
  logic [3:0]   rounds_r;
  logic [127:0] key_r;
  logic         wr;
  logic [1:0]   idx;
  logic [3:0]   sat;

  aes_pkg::ctl_t ctl [aes_pkg::Stages];
  logic [127:0]  st  [aes_pkg::Stages];
  logic [127:0]  rk  [aes_pkg::Stages];
  aes_pkg::ctl_t ctl0_r;
  logic [127:0]  st0_r, rk0_r;

  assign busy       = 1'b0;
  assign cfg_pready = 1'b1;
  // byte lanes within a register are not decoded
  assign idx = cfg_paddr[4:3];
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rounds_r <= aes_pkg::MaxRounds;
      key_r    <= '0;
    end else if (wr) begin
      case (idx)
        aes_pkg::REG_ROUNDS: rounds_r <= cfg_pwdata[3:0];
        aes_pkg::REG_KEY_HI: key_r[127:64] <= cfg_pwdata;
        aes_pkg::REG_KEY_LO: key_r[63:0] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      aes_pkg::REG_ROUNDS: cfg_prdata = {60'd0, rounds_r};
      aes_pkg::REG_KEY_HI: cfg_prdata = key_r[127:64];
      aes_pkg::REG_KEY_LO: cfg_prdata = key_r[63:0];
      default:             cfg_prdata = '0;
    endcase
  end

  assign sat = (rounds_r > aes_pkg::MaxRounds) ? aes_pkg::MaxRounds : rounds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else begin
      ctl0_r <= '{vld: start, rounds: sat};
    end
    st0_r <= in_payload ^ key_r;
    rk0_r <= key_r;
  end

  assign ctl[0] = ctl0_r;
  assign st[0]  = st0_r;
  assign rk[0]  = rk0_r;

  for (genvar g = 0; g < aes_pkg::Stages - 1; g++) begin : g_rnd
    aes_round u_rnd (
      .clk     (clk),
      .rst_n   (rst_n),
      .step    (4'(g)),
      .ctl_in  (ctl[g]),
      .st_in   (st[g]),
      .key_in  (rk[g]),
      .ctl_out (ctl[g+1]),
      .st_out  (st[g+1]),
      .key_out (rk[g+1])
    );
  end

  assign out_strobe  = ctl[aes_pkg::Stages-1].vld;
  assign out_payload = st[aes_pkg::Stages-1];
endmodule
`default_nettype wire

FILE: rtl/core/aes_checker.sv
`default_nettype none
`include "aes128_block_encrypt_macros.svh"
module aes_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_strobe,
  input wire logic cfg_pready
);
  // every request gives a strobe
  `AES_ASSERT(a_lat, start && !busy |-> ##11 out_strobe, "missing result")
  // no strobe without a request
  `AES_ASSERT(a_none, out_strobe |-> $past(start && !busy, 11), "stray result")
  `AES_ASSERT(a_rdy, cfg_pready && !busy, "port not ready")
endmodule

bind aes128_block_encrypt aes_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .cfg_pready(cfg_pready)
);
`default_nettype wire

FILE: bench/tb.sv
module tb;

  localparam int Latency = 11;
  localparam int StallLimit = 2000;
  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
  localparam logic [7:0] Rcon [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                       8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  int errors = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  class cipher_board;
    logic [3:0] rounds = aes_pkg::MaxRounds;
    logic [127:0] key = '0;
    aes_pkg::out_t pending[$];

    function automatic logic [7:0] dbl(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic aes_pkg::out_t encrypt(input aes_pkg::in_t blk);
      logic [7:0] s [16];
      logic [7:0] k [16];
      logic [7:0] t [16];
      logic [7:0] w [4];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] v;
      int n;
      v = {blk.data_high, blk.data_low};
      n = (rounds > aes_pkg::MaxRounds) ? 10 : int'(rounds);
      for (int i = 0; i < 16; i++) begin
        k[i] = key[127-8*i -: 8];
        s[i] = v[127-8*i -: 8] ^ k[i];
      end
      for (int rd = 1; rd <= n; rd++) begin
        // key schedule step: rotword, subword, rcon, then chain the columns
        for (int r = 0; r < 4; r++) w[r] = Sbox[k[((r + 1) % 4) * 4 + 3]];
        w[0] ^= Rcon[rd - 1];
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) begin
            k[r*4+c] ^= w[r];
            w[r] = k[r*4+c];
          end
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) t[r*4+c] = Sbox[s[r*4 + (c + r) % 4]];
        if (rd != n) begin
          for (int c = 0; c < 4; c++) begin
            a0 = t[c]; a1 = t[c+4]; a2 = t[c+8]; a3 = t[c+12];
            t[c]    = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
            t[c+4]  = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
            t[c+8]  = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
            t[c+12] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
          end
        end
        for (int i = 0; i < 16; i++) s[i] = t[i] ^ k[i];
      end
      for (int i = 0; i < 16; i++) v[127-8*i -: 8] = s[i];
      return v;
    endfunction

    function void note_request(input aes_pkg::in_t blk);
      pending.push_back(encrypt(blk));
    endfunction

    task check_result(input aes_pkg::out_t got);
      aes_pkg::out_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got.cipher_high, '0);
        return;
      end
      want = pending.pop_front();
      if (got.cipher_high !== want.cipher_high)
        report("cipher_high", got.cipher_high, want.cipher_high);
      if (got.cipher_low !== want.cipher_low)
        report("cipher_low", got.cipher_low, want.cipher_low);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  aes_pkg::in_t in_payload = '0;
  logic out_strobe;
  aes_pkg::out_t out_payload;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [4:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  cipher_board board = new();
  int idle_pct = 26;
  int quiet = 0;

  aes128_block_encrypt uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_payload(in_payload),
    .out_strobe(out_strobe), .out_payload(out_payload),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) board.check_result(out_payload);
      if ((start && !busy) || out_strobe) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_reg(input aes_pkg::reg_idx_t idx, input logic [63:0] value);
    @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= 5'(idx) << 3; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (idx)
      aes_pkg::REG_ROUNDS: board.rounds = value[3:0];
      aes_pkg::REG_KEY_HI: board.key[127:64] = value;
      aes_pkg::REG_KEY_LO: board.key[63:0] = value;
      default: ;
    endcase
  endtask

  // start is held across back-to-back requests, lowered only for idle cycles
  task automatic send_block(input aes_pkg::in_t blk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_payload <= blk;
    do @(posedge clk); while (busy);
    board.note_request(blk);
  endtask

  task automatic go_idle();
    start <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
  endtask

  function automatic aes_pkg::in_t rand_block();
    aes_pkg::in_t b;
    b.data_high = {$urandom, $urandom};
    b.data_low = {$urandom, $urandom};
    return b;
  endfunction

  initial begin
    logic [3:0] rsel;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset setting: ten rounds, zero key
    send_block('0);
    send_block('1);
    go_idle();
    // standard test vector
    write_reg(aes_pkg::REG_KEY_HI, 64'h2b7e151628aed2a6);
    write_reg(aes_pkg::REG_KEY_LO, 64'habf7158809cf4f3c);
    send_block({64'h3243f6a8885a308d, 64'h313198a2e0370734});
    send_block('0);
    send_block('1);
    go_idle();
    write_reg(aes_pkg::REG_ROUNDS, 4'd0);
    send_block({64'h0123456789abcdef, 64'hfedcba9876543210});
    send_block('1);
    go_idle();
    // counts above ten saturate
    write_reg(aes_pkg::REG_ROUNDS, 4'd15);
    write_reg(aes_pkg::REG_KEY_HI, '1);
    write_reg(aes_pkg::REG_KEY_LO, '1);
    send_block('0);
    send_block('1);
    go_idle();
    for (int n = 1; n <= 12; n++) begin
      write_reg(aes_pkg::REG_ROUNDS, 4'(n));
      send_block(rand_block());
      go_idle();
    end

    for (int ph = 0; ph < 15; ph++) begin
      rsel = (ph % 3 == 0) ? 4'($urandom_range(15)) : ((ph % 3 == 1) ? 4'd10 : 4'd0);
      write_reg(aes_pkg::REG_ROUNDS, rsel);
      write_reg(aes_pkg::REG_KEY_HI, (ph == 4) ? 64'h0 : {$urandom, $urandom});
      write_reg(aes_pkg::REG_KEY_LO, (ph == 5) ? '1 : {$urandom, $urandom});
      idle_pct = (ph == 7) ? 0 : 26;
      for (int i = 0; i < 50; i++) send_block(rand_block());
      go_idle();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/aes_pkg.sv
rtl/core/aes_round.sv
rtl/core/aes128_block_encrypt.sv
rtl/core/aes_checker.sv
bench/tb.sv
